>>> rtl/core/csu_pkg.sv
// Shared types and constants for the CSR slot unit.
// No dependencies; imported by every module of the block.
package csu_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 8;
    localparam int unsigned CSR_BASE_DEF   = 2048;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int CNT_W  = 32;
    localparam int LAT_W  = 8;

    localparam logic [LAT_W-1:0] LAT_RESET = 8'd1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WAIT  = 4'b0010,
        PH_RESP  = 4'b0100,
        PH_RECOV = 4'b1000
    } phase_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // request taken in idle this beat
        logic count_resp;  // responding phase completes this beat
        logic resp_phase;  // phase after the last beat is responding
    } csu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [LAT_W-1:0] latency;
    } csu_status_t;

endpackage

>>> rtl/core/csu_ctrl.sv
// Phase controller of the CSR slot unit: phase, latency countdown and
// result handshake. Depends on csu_pkg.
module csu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                req,
    output logic                result_valid,
    input  logic                result_stall,
    input  csu_pkg::csu_status_t status,
    output csu_pkg::csu_cmd_t    cmd
);
    import csu_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [LAT_W-1:0]  ticks_left_reg, ticks_left_next;
    logic              result_valid_reg, result_valid_next;
    logic              step;

    assign item_stall   = result_valid_reg & result_stall;
    assign step         = item_valid & ~item_stall;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        ticks_left_next = ticks_left_reg;
        cmd.accept      = 1'b0;
        cmd.count_resp  = 1'b0;
        cmd.resp_phase  = (phase_reg == PH_RESP);
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req)
                    begin
                        cmd.accept = 1'b1;
                        if (status.latency <= LAT_W'(1))
                        begin
                            phase_next      = PH_RESP;
                            ticks_left_next = '0;
                        end
                        else
                        begin
                            phase_next      = PH_WAIT;
                            ticks_left_next = status.latency - LAT_W'(1);
                        end
                    end
                end
                PH_WAIT:
                begin
                    if (ticks_left_reg > LAT_W'(1))
                    begin
                        ticks_left_next = ticks_left_reg - LAT_W'(1);
                    end
                    else
                    begin
                        ticks_left_next = '0;
                        phase_next      = PH_RESP;
                    end
                end
                PH_RESP:
                begin
                    cmd.count_resp = 1'b1;
                    phase_next     = PH_RECOV;
                end
                PH_RECOV:
                begin
                    if (!req)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg & result_stall;
        if (step)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            ticks_left_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            ticks_left_reg   <= ticks_left_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (step && phase_reg == PH_IDLE))
        else $error("request accepted outside idle");

    a_resp_to_recov: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_RESP) |=> (phase_reg == PH_RECOV))
        else $error("responding phase did not move to recovery");

    a_hold_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(ticks_left_reg)))
        else $error("phase moved without an input beat");

    a_wait_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_WAIT && ticks_left_reg > LAT_W'(1))
            |=> (phase_reg == PH_WAIT))
        else $error("wait phase left early");

endmodule

>>> rtl/core/csu_dpath.sv
// Datapath of the CSR slot unit: slot memory, read latch, counters and the
// latency register. Depends on csu_pkg; driven by csu_ctrl commands.
module csu_dpath #(
    parameter int unsigned SLOT_COUNT = csu_pkg::SLOT_COUNT_DEF,
    parameter int unsigned CSR_BASE   = csu_pkg::CSR_BASE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csu_pkg::LAT_W-1:0]         cfg_data,
    input  logic                              csr_read,
    input  logic                              csr_write,
    input  logic [csu_pkg::ADDR_W-1:0]        csr_addr,
    input  logic [csu_pkg::DATA_W-1:0]        write_data,
    input  csu_pkg::csu_cmd_t                 cmd,
    output csu_pkg::csu_status_t              status,
    output logic [csu_pkg::HALF_W-1:0]        read_data,
    output logic [csu_pkg::CNT_W-1:0]         accepted_count,
    output logic [csu_pkg::CNT_W-1:0]         response_count
);
    import csu_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [ADDR_W:0]   WIN_SIZE = (ADDR_W + 1)'(2 * SLOT_COUNT);
    localparam logic [ADDR_W-1:0] BASE     = ADDR_W'(CSR_BASE);

    logic [DATA_W-1:0]     slot_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_vld_reg;
    logic [DATA_W-1:0]     mem_q_reg;
    logic [HALF_W-1:0]     byp_data_reg;
    logic                  rd_hit_reg, byp_reg, vld_reg, odd_reg;
    logic [LAT_W-1:0]      lat_reg, lat_next;
    logic [CNT_W-1:0]      acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0]      resp_cnt_reg, resp_cnt_next;

    logic [ADDR_W-1:0]     offset;
    logic                  hit;
    logic [IDX_W-1:0]      idx;
    logic                  wr_en;
    logic [HALF_W-1:0]     latched_read;

    assign offset = csr_addr - BASE;
    assign hit    = (csr_addr >= BASE) && ({1'b0, offset} < WIN_SIZE);
    assign idx    = offset[IDX_W:1];
    assign wr_en  = cmd.accept & csr_write & hit & ~offset[0];

    assign cfg_ready      = 1'b1;
    assign status.latency = lat_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[idx] <= write_data;
        end
        if (cmd.accept)
        begin
            mem_q_reg    <= slot_mem[idx];
            byp_data_reg <= write_data[HALF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            rd_hit_reg   <= 1'b0;
            byp_reg      <= 1'b0;
            vld_reg      <= 1'b0;
            odd_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_vld_reg[idx] <= 1'b1;
            end
            if (cmd.accept)
            begin
                rd_hit_reg <= csr_read & hit;
                byp_reg    <= wr_en;
                vld_reg    <= slot_vld_reg[idx];
                odd_reg    <= offset[0];
            end
        end
    end

    // same-beat write wins over the old slot contents
    always_comb
    begin
        if (!rd_hit_reg)
        begin
            latched_read = '0;
        end
        else if (byp_reg)
        begin
            latched_read = byp_data_reg;
        end
        else if (!vld_reg)
        begin
            latched_read = '0;
        end
        else if (odd_reg)
        begin
            latched_read = mem_q_reg[DATA_W-1:HALF_W];
        end
        else
        begin
            latched_read = mem_q_reg[HALF_W-1:0];
        end
    end

    always_comb
    begin
        lat_next      = (cfg_valid && cfg_ready) ? cfg_data : lat_reg;
        acc_cnt_next  = cmd.accept ? acc_cnt_reg + CNT_W'(1) : acc_cnt_reg;
        resp_cnt_next = cmd.count_resp ? resp_cnt_reg + CNT_W'(1) : resp_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg      <= LAT_RESET;
            acc_cnt_reg  <= '0;
            resp_cnt_reg <= '0;
        end
        else
        begin
            lat_reg      <= lat_next;
            acc_cnt_reg  <= acc_cnt_next;
            resp_cnt_reg <= resp_cnt_next;
        end
    end

    assign read_data      = cmd.resp_phase ? latched_read : '0;
    assign accepted_count = acc_cnt_reg;
    assign response_count = resp_cnt_reg;

    a_count_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (acc_cnt_reg == $past(acc_cnt_reg) + CNT_W'(1)))
        else $error("accepted count did not advance by one");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.accept && !cmd.count_resp)
            |=> ($stable(acc_cnt_reg) && $stable(resp_cnt_reg)))
        else $error("counter moved without a command");

    a_read_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.resp_phase |-> (read_data == '0))
        else $error("read data outside responding phase");

endmodule

>>> rtl/core/csr_slot_unit_with_latency.sv
// Top level of the CSR slot unit: joins the phase controller and datapath.
// Depends on csu_pkg, csu_ctrl and csu_dpath.
//
// Every input beat is one tick of the unit and yields exactly one result beat
// holding the state after that tick. Results sit in one output register, so a
// beat is taken every cycle while result_stall is low; item_stall rises only
// while a result waits. The response latency counts input beats, with zero treated
// as the minimum; a new value applies from the next accepted request. The
// configuration port is always ready. Slot memory is reset by per-slot valid
// flags, so no clearing pass is needed after reset.
module csr_slot_unit_with_latency #(
    parameter int unsigned SLOT_COUNT = csu_pkg::SLOT_COUNT_DEF,
    parameter int unsigned CSR_BASE   = csu_pkg::CSR_BASE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csu_pkg::LAT_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          csr_read,
    input  logic                          csr_write,
    input  logic [csu_pkg::ADDR_W-1:0]    csr_addr,
    input  logic [csu_pkg::DATA_W-1:0]    write_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          response_valid,
    output logic [csu_pkg::HALF_W-1:0]    read_data,
    output logic [csu_pkg::CNT_W-1:0]     accepted_count,
    output logic [csu_pkg::CNT_W-1:0]     response_count
);
    import csu_pkg::*;

    csu_cmd_t    cmd;
    csu_status_t status;

    csu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req          (csr_read | csr_write),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    csu_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .CSR_BASE   (CSR_BASE)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .csr_read       (csr_read),
        .csr_write      (csr_write),
        .csr_addr       (csr_addr),
        .write_data     (write_data),
        .cmd            (cmd),
        .status         (status),
        .read_data      (read_data),
        .accepted_count (accepted_count),
        .response_count (response_count)
    );

    assign response_valid = cmd.resp_phase;

endmodule

>>> test/tb_csr_slot_unit_with_latency.sv
// Self-checking testbench for csr_slot_unit_with_latency: predicts every tick's result
// and compares it beat by beat under random idling and output back-pressure.
// Depends on csu_pkg and the csr_slot_unit_with_latency RTL only.
module tb_csr_slot_unit_with_latency;

    timeunit 1ns;
    timeprecision 1ps;

    import csu_pkg::*;

    localparam int unsigned WINDOW = 2 * SLOT_COUNT_DEF;
    localparam logic [ADDR_W-1:0] BASE_ADDR = ADDR_W'(CSR_BASE_DEF);

    typedef struct packed {
        logic              resp_valid;
        logic [HALF_W-1:0] read_half;
        logic [CNT_W-1:0]  accepted;
        logic [CNT_W-1:0]  responded;
    } tick_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LAT_W-1:0]    cfg_data;
    logic                item_valid;
    logic                item_stall;
    logic                csr_read;
    logic                csr_write;
    logic [ADDR_W-1:0]   csr_addr;
    logic [DATA_W-1:0]   write_data;
    logic                result_valid;
    logic                result_stall;
    logic                response_valid;
    logic [HALF_W-1:0]   read_data;
    logic [CNT_W-1:0]    accepted_count;
    logic [CNT_W-1:0]    response_count;

    // predicted unit state
    phase_t              model_phase;
    logic [LAT_W-1:0]    model_ticks;
    logic [LAT_W-1:0]    model_latency;
    logic [HALF_W-1:0]   model_latched;
    logic [DATA_W-1:0]   model_slots [SLOT_COUNT_DEF];
    logic [CNT_W-1:0]    model_accepted;
    logic [CNT_W-1:0]    model_responded;

    tick_result_t        expected_results [$];
    int                  errors = 0;
    int                  tick_count = 0;
    bit                  idle_on = 1'b1;
    bit                  hold_req = 1'b0;

    csr_slot_unit_with_latency DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .csr_read       (csr_read),
        .csr_write      (csr_write),
        .csr_addr       (csr_addr),
        .write_data     (write_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .response_valid (response_valid),
        .read_data      (read_data),
        .accepted_count (accepted_count),
        .response_count (response_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** csr_slot_unit_with_latency: FAILED **");
        $finish;
    end

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic logic [ADDR_W-1:0] window_addr();
        return BASE_ADDR + ADDR_W'($urandom_range(0, WINDOW - 1));
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one tick of the unit; state after the tick is returned
    function automatic tick_result_t step_unit(logic rd, logic wr, logic [ADDR_W-1:0] addr,
                                               logic [DATA_W-1:0] data);
        tick_result_t res;
        int unsigned  lat;
        int unsigned  off;
        int unsigned  idx;
        bit           hit;
        case (model_phase)
            PH_IDLE:
            begin
                if (rd || wr)
                begin
                    lat = (model_latency == 0) ? 1 : model_latency;
                    hit = addr >= CSR_BASE_DEF && addr < CSR_BASE_DEF + WINDOW;
                    off = hit ? addr - CSR_BASE_DEF : 0;
                    idx = off >> 1;
                    model_accepted++;
                    if (wr && hit && off[0] == 1'b0)
                        model_slots[idx] = data;
                    if (rd && hit)
                        model_latched = off[0] ? model_slots[idx][63:32] : model_slots[idx][31:0];
                    else
                        model_latched = '0;
                    if (lat == 1)
                    begin
                        model_phase = PH_RESP;
                        model_ticks = '0;
                    end
                    else
                    begin
                        model_phase = PH_WAIT;
                        model_ticks = LAT_W'(lat - 1);
                    end
                end
            end
            PH_WAIT:
            begin
                if (model_ticks > 1)
                    model_ticks--;
                else
                begin
                    model_ticks = '0;
                    model_phase = PH_RESP;
                end
            end
            PH_RESP:
            begin
                model_responded++;
                model_phase = PH_RECOV;
            end
            default:
            begin
                if (!(rd || wr))
                    model_phase = PH_IDLE;
            end
        endcase
        res.resp_valid = (model_phase == PH_RESP);
        res.read_half  = res.resp_valid ? model_latched : '0;
        res.accepted   = model_accepted;
        res.responded  = model_responded;
        return res;
    endfunction

    task automatic send_tick(input logic rd, input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 9) < 2)
        begin
            item_valid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        csr_read   = rd;
        csr_write  = wr;
        csr_addr   = addr;
        write_data = data;
        item_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        expected_results.push_back(step_unit(rd, wr, addr, data));
        tick_count++;
    endtask

    task automatic send_quiet_tick();
        send_tick(1'b0, 1'b0, ADDR_W'($urandom_range(0, 4095)), rand64());
    endtask

    // request, then ticks until the unit is back in idle; noise_pct of them carry a request
    task automatic issue_request(input logic rd, input logic wr, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] data, input int noise_pct);
        send_tick(rd, wr, addr, data);
        while (model_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_tick(1'b1, 1'($urandom_range(0, 1)), window_addr(), rand64());
            else
                send_quiet_tick();
        end
    endtask

    task automatic drain_items();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_latency(input logic [LAT_W-1:0] value);
        drain_items();
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        model_latency = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_slot_access();
        issue_request(1'b0, 1'b1, BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        issue_request(1'b0, 1'b1, BASE_ADDR + ADDR_W'(14), 64'h8000_0000_0000_0001, 0);
        issue_request(1'b1, 1'b0, BASE_ADDR, '0, 0);
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(1), '0, 0);
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(15), '0, 0);
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(14), '0, 0);
        // odd offset: write dropped, read of the high half still done
        issue_request(1'b1, 1'b1, BASE_ADDR + ADDR_W'(3), 64'h1234_5678_9ABC_DEF0, 0);
        // read and write together: read sees the new word
        issue_request(1'b1, 1'b1, BASE_ADDR + ADDR_W'(2), 64'hA5A5_5A5A_0F0F_F0F0, 0);
        issue_request(1'b0, 1'b1, BASE_ADDR + ADDR_W'(4), 64'h0, 0);
        issue_request(1'b1, 1'b0, BASE_ADDR - ADDR_W'(1), '0, 0);
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(WINDOW), '0, 0);
        issue_request(1'b0, 1'b1, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        issue_request(1'b1, 1'b0, 12'h000, '0, 0);
        issue_request(1'b1, 1'b0, 12'hFFF, '0, 0);
    endtask

    task automatic test_busy_requests();
        write_latency(8'd3);
        send_tick(1'b1, 1'b0, BASE_ADDR, '0);
        send_tick(1'b0, 1'b1, BASE_ADDR + ADDR_W'(6), 64'hDEAD_BEEF_0000_FFFF);
        send_tick(1'b1, 1'b1, BASE_ADDR + ADDR_W'(6), 64'hDEAD_BEEF_0000_FFFF);
        send_tick(1'b1, 1'b0, BASE_ADDR + ADDR_W'(1), '0);
        send_tick(1'b0, 1'b1, BASE_ADDR + ADDR_W'(6), 64'hDEAD_BEEF_0000_FFFF);
        send_quiet_tick();
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(6), '0, 0);
    endtask

    task automatic test_latency_extremes();
        write_latency(8'd0);
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(1), '0, 0);
        issue_request(1'b1, 1'b1, BASE_ADDR + ADDR_W'(12), 64'h0123_4567_89AB_CDEF, 0);
        write_latency(8'd255);
        issue_request(1'b1, 1'b0, BASE_ADDR + ADDR_W'(13), '0, 5);
    endtask

    task automatic test_output_backpressure();
        write_latency(8'd1);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (8)
            issue_request(1'b1, 1'($urandom_range(0, 1)), window_addr(), rand64(), 20);
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [LAT_W-1:0]  lat_plan [6];
        logic [ADDR_W-1:0] a;
        int                stop_at;
        int                kind;
        lat_plan[0] = 8'd0;
        lat_plan[1] = 8'd1;
        lat_plan[2] = 8'd2;
        lat_plan[3] = LAT_W'($urandom_range(3, 8));
        lat_plan[4] = LAT_W'($urandom_range(9, 20));
        lat_plan[5] = LAT_W'($urandom_range(0, 5));
        for (int p = 0; p < 6; p++)
        begin
            write_latency(lat_plan[p]);
            idle_on = (p != 3);
            stop_at = tick_count + 80;
            while (tick_count < stop_at)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    kind = $urandom_range(0, 2);
                    a = ($urandom_range(0, 9) < 9) ? window_addr()
                                                   : ADDR_W'($urandom_range(0, 4095));
                    issue_request(kind != 1, kind != 0, a, rand64(), 10);
                end
                else
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              ADDR_W'($urandom_range(0, 4095)), rand64());
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic report_field(input string label, input logic [CNT_W-1:0] want,
                                input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with no expectation, expected none, actual %h %h %h %h",
                         $time, response_valid, read_data, accepted_count, response_count);
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("response_valid", want.resp_valid, response_valid);
                report_field("read_data", want.read_half, read_data);
                report_field("accepted_count", want.accepted, accepted_count);
                report_field("response_count", want.responded, response_count);
            end
        end
    end

    // receiver: random stalls, plus a long hold when asked
    initial
    begin : result_side
        int unsigned hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                result_stall = 1'b1;
                hold_left--;
            end
            else if (idle_on && $urandom_range(0, 9) < 2)
            begin
                result_stall = 1'b1;
                hold_left    = pick_gap() - 1;
            end
            else
                result_stall = 1'b0;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        item_valid = 1'b0;
        csr_read   = 1'b0;
        csr_write  = 1'b0;
        csr_addr   = '0;
        write_data = '0;
        model_phase     = PH_IDLE;
        model_ticks     = '0;
        model_latency   = LAT_RESET;
        model_latched   = '0;
        model_accepted  = '0;
        model_responded = '0;
        foreach (model_slots[i])
            model_slots[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_slot_access();
        test_busy_requests();
        test_latency_extremes();
        test_output_backpressure();
        test_random_traffic();

        drain_items();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("** csr_slot_unit_with_latency: PASSED **");
        else
            $display("** csr_slot_unit_with_latency: FAILED **");
        $finish;
    end

endmodule
